FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the link parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define ASSERT_ON(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/mdlink_pkg.sv
// Package for the markdown link parser: character codes, result type, helpers.
package mdlink_pkg;

  localparam int LINE_MAX_DEF = 4096;
  localparam int CH_W         = 8;
  localparam int POS_OUT_W    = 12;

  localparam logic [CH_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CH_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic                 valid_res;
    logic [POS_OUT_W-1:0] close_bracket_pos;
    logic [POS_OUT_W-1:0] open_paren_pos;
    logic [POS_OUT_W-1:0] close_paren_pos;
  } res_t;

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

FILE: hw/rtl/mdlink_scan.sv
// Link scan state and per-character update, one word per step.
`include "assert_macros.svh"

module mdlink_scan #(
  parameter int LINE_MAX = mdlink_pkg::LINE_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic [mdlink_pkg::CH_W-1:0]         ch,
  input  logic                                first,
  input  logic                                last,
  input  logic [mdlink_pkg::POS_OUT_W-1:0]    open_pos,
  output logic                                done,
  output mdlink_pkg::res_t                    res
);
  import mdlink_pkg::*;

  localparam int POS_W = $clog2(LINE_MAX);
  localparam int EXT_W = ((POS_W > POS_OUT_W) ? POS_W : POS_OUT_W) + 1;
  localparam logic [EXT_W-1:0] POS_MAX = EXT_W'(LINE_MAX - 1);

  logic             scanning, scanning_next;
  logic             in_anchor, in_anchor_next;
  logic             in_target, in_target_next;
  logic             anchor_has_text, anchor_has_text_next;
  logic             target_has_text, target_has_text_next;
  logic [POS_W-1:0] cur_pos, cur_pos_next;
  logic [POS_W-1:0] bracket_start, bracket_start_next;
  logic [POS_W-1:0] bracket_end, bracket_end_next;
  logic [POS_W-1:0] paren_start, paren_start_next;

  logic             active;
  logic             stop;
  logic             link_ok;
  logic [EXT_W-1:0] opos_ext;
  logic [EXT_W-1:0] opos_inc;
  logic [EXT_W-1:0] cur_inc;
  logic [POS_W-1:0] close_paren;
  logic [EXT_W-1:0] be_ext, ps_ext, cp_ext;

  always_comb begin
    opos_ext = EXT_W'(open_pos);
    opos_inc = opos_ext + EXT_W'(1);
    cur_inc  = EXT_W'(cur_pos) + EXT_W'(1);
    active   = first || scanning;

    in_anchor_next       = in_anchor;
    in_target_next       = in_target;
    anchor_has_text_next = anchor_has_text;
    target_has_text_next = target_has_text;
    bracket_start_next   = bracket_start;
    bracket_end_next     = bracket_end;
    paren_start_next     = paren_start;

    if (first) begin
      in_anchor_next       = 1'b1;
      in_target_next       = 1'b0;
      anchor_has_text_next = 1'b0;
      target_has_text_next = 1'b0;
      bracket_start_next   = (opos_ext > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(opos_ext);
      bracket_end_next     = bracket_start_next;
      paren_start_next     = bracket_start_next;
      cur_pos_next         = (opos_inc > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(opos_inc);
    end else begin
      cur_pos_next = (cur_inc > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(cur_inc);
    end

    stop        = 1'b0;
    link_ok     = 1'b0;
    close_paren = bracket_start_next;

    priority if (ch == CH_LBRACK && in_anchor_next) begin
      stop = 1'b1;
    end else if (ch == CH_RBRACK && in_anchor_next) begin
      bracket_end_next = cur_pos_next;
      in_anchor_next   = 1'b0;
    end else if (ch == CH_LPAREN && !in_anchor_next && in_target_next) begin
      stop = 1'b1;
    end else if (ch == CH_LPAREN && !in_anchor_next) begin
      paren_start_next = cur_pos_next;
      in_target_next   = 1'b1;
    end else if (ch == CH_RPAREN && in_target_next) begin
      close_paren    = cur_pos_next;
      in_target_next = 1'b0;
      stop           = 1'b1;
      link_ok        = ((POS_W + 1)'(paren_start_next) == (POS_W + 1)'(bracket_end_next) +
                        (POS_W + 1)'(1)) && anchor_has_text_next && target_has_text_next;
    end else begin
      if (!is_space(ch)) begin
        if (in_anchor_next) anchor_has_text_next = 1'b1;
        if (in_target_next) target_has_text_next = 1'b1;
      end
    end

    done          = active && (stop || last);
    scanning_next = active && !(stop || last);
    if (done) begin
      in_anchor_next = 1'b0;
      in_target_next = 1'b0;
    end

    be_ext                = EXT_W'(bracket_end_next);
    ps_ext                = EXT_W'(paren_start_next);
    cp_ext                = EXT_W'(close_paren);
    res.valid_res         = link_ok;
    res.close_bracket_pos = be_ext[POS_OUT_W-1:0];
    res.open_paren_pos    = ps_ext[POS_OUT_W-1:0];
    res.close_paren_pos   = cp_ext[POS_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning        <= 1'b0;
      in_anchor       <= 1'b0;
      in_target       <= 1'b0;
      anchor_has_text <= 1'b0;
      target_has_text <= 1'b0;
      cur_pos         <= '0;
      bracket_start   <= '0;
      bracket_end     <= '0;
      paren_start     <= '0;
    end else if (step && active) begin
      scanning        <= scanning_next;
      in_anchor       <= in_anchor_next;
      in_target       <= in_target_next;
      anchor_has_text <= anchor_has_text_next;
      target_has_text <= target_has_text_next;
      cur_pos         <= cur_pos_next;
      bracket_start   <= bracket_start_next;
      bracket_end     <= bracket_end_next;
      paren_start     <= paren_start_next;
    end
  end

  `ASSERT_ON(a_valid_adjacent, clk, rst,
    (step && done && res.valid_res) |-> (res.open_paren_pos != res.close_bracket_pos),
    "valid link with paren on bracket")
  `ASSERT_ON(a_flags_idle, clk, rst, !scanning |-> (!in_anchor && !in_target),
    "part flags set while idle")
  `ASSERT_ON(a_anchor_target, clk, rst, !(in_anchor && in_target),
    "in anchor and target at once")

endmodule

FILE: hw/rtl/markdown_link_parser.sv
// Markdown inline link parser top level: input register, scan step, result register.
//
// Usage: after a '[' is found on a line, send the following characters one word
// per cycle on the input channel (in_valid / in_stall). Set first on the word
// right after the '[' with open_pos holding the bracket position; set last on
// the final character of the line. When the scan closes (on ')', an abort or
// end of line) one result word appears on the output channel (out_valid /
// out_stall) with valid_res and the three positions; other words give none.
// Words with first low while no scan runs are dropped.
// A result passes from the input register through the scan step into the result
// register; an output stall can hold its word in the input register between the two.
// Throughput: one word per cycle while the output is not stalled; the scan state
// updates once per word in a single register-to-register pass.
// Reset clears the scan state and the valid flags of both word registers; nothing
// is lost or emitted afterwards until new words arrive.
// A stall on the output holds the result word; the input register then fills
// and in_stall rises until the result is taken.
`include "assert_macros.svh"

module markdown_link_parser #(
  parameter int LINE_MAX = mdlink_pkg::LINE_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mdlink_pkg::CH_W-1:0]         ch,
  input  logic                                first,
  input  logic                                last,
  input  logic [mdlink_pkg::POS_OUT_W-1:0]    open_pos,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                valid_res,
  output logic [mdlink_pkg::POS_OUT_W-1:0]    close_bracket_pos,
  output logic [mdlink_pkg::POS_OUT_W-1:0]    open_paren_pos,
  output logic [mdlink_pkg::POS_OUT_W-1:0]    close_paren_pos
);
  import mdlink_pkg::*;

  logic                 word_vld;
  logic [CH_W-1:0]      ch_q;
  logic                 first_q;
  logic                 last_q;
  logic [POS_OUT_W-1:0] open_pos_q;
  logic                 advance;
  logic                 out_free;
  logic                 done;
  res_t                 res;

  assign out_free = !out_valid || !out_stall;
  assign advance  = word_vld && out_free;
  assign in_stall = word_vld && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_vld <= 1'b0;
    end else if (!in_stall) begin
      word_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ch_q       <= ch;
      first_q    <= first;
      last_q     <= last;
      open_pos_q <= open_pos;
    end
  end

  mdlink_scan #(
    .LINE_MAX(LINE_MAX)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .ch       (ch_q),
    .first    (first_q),
    .last     (last_q),
    .open_pos (open_pos_q),
    .done     (done),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && done;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && done) begin
      valid_res         <= res.valid_res;
      close_bracket_pos <= res.close_bracket_pos;
      open_paren_pos    <= res.open_paren_pos;
      close_paren_pos   <= res.close_paren_pos;
    end
  end

  `ASSERT_ALL(a_reset_empty, clk, rst |=> (!out_valid && !in_stall),
    "words left after reset")
  `ASSERT_ON(a_stall_needs_word, clk, rst,
    in_stall |-> (word_vld && out_valid && out_stall), "input stalled without cause")
  `ASSERT_ON(a_result_held, clk, rst, (out_valid && out_stall) |=> out_valid,
    "result dropped under stall")

endmodule
